// ===== rtl/core/ips_pkg.sv =====
// Shared types and constants of the image placement scaler.
package ips_pkg;

   localparam int DIM_BITS           = 13;
   localparam int PROD_BITS          = 2 * DIM_BITS;
   localparam int SIZE_BITS          = 16;
   localparam int OFF_BITS           = SIZE_BITS + 2;
   localparam int CSR_DATA_BITS      = 2;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = SIZE_BITS / DIV_BITS_PER_STAGE;

   localparam int ST_A       = 0;
   localparam int ST_B       = 1;
   localparam int ST_C       = 2;
   localparam int ST_D       = 3;
   localparam int ST_E       = 4;
   localparam int ST_DIV0    = 5;
   localparam int ST_F       = ST_DIV0 + DIV_STAGES;
   localparam int ST_OUT     = ST_F + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef enum logic [1:0] {
      MODE_CENTER  = 2'd0,
      MODE_ZOOM    = 2'd1,
      MODE_STRETCH = 2'd2,
      MODE_FIT     = 2'd3
   } scale_mode_type;

   typedef enum logic [0:0] {
      CSR_SCALE_MODE    = 1'b0,
      CSR_ROTATE_ENABLE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      QSEL_NONE   = 2'd0,
      QSEL_WIDTH  = 2'd1,
      QSEL_HEIGHT = 2'd2
   } quot_sel_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] image_width;
      logic [DIM_BITS-1:0] image_height;
      logic [DIM_BITS-1:0] monitor_x;
      logic [DIM_BITS-1:0] monitor_y;
      logic [DIM_BITS-1:0] monitor_width;
      logic [DIM_BITS-1:0] monitor_height;
   } req_word_type;

   typedef struct packed {
      logic signed [SIZE_BITS-1:0] dest_x;
      logic signed [SIZE_BITS-1:0] dest_y;
      logic [SIZE_BITS-1:0]        dest_width;
      logic [SIZE_BITS-1:0]        dest_height;
      logic                        rotated;
      logic                        saturated;
   } rsp_word_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] base_w;
      logic [DIM_BITS-1:0] base_h;
      logic [DIM_BITS-1:0] mw;
      logic [DIM_BITS-1:0] mh;
      logic [DIM_BITS-1:0] mx;
      logic [DIM_BITS-1:0] my;
      logic                rotated;
      quot_sel_type        qsel;
   } side_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  iw;
      logic [DIM_BITS-1:0]  ih;
      logic [DIM_BITS-1:0]  mw;
      logic [DIM_BITS-1:0]  mh;
      logic [DIM_BITS-1:0]  mx;
      logic [DIM_BITS-1:0]  my;
      scale_mode_type       mode;
      logic                 rotated;
      logic [PROD_BITS-1:0] p_iw_mh;
      logic [PROD_BITS-1:0] p_mw_ih;
   } stage_b_type;

   typedef struct packed {
      side_type             side;
      logic [PROD_BITS-1:0] dividend;
      logic [DIM_BITS-1:0]  divisor;
      logic                 ceil_div;
   } stage_c_type;

   typedef struct packed {
      side_type             side;
      logic [PROD_BITS-1:0] numer;
      logic [DIM_BITS-1:0]  divisor;
   } stage_d_type;

   typedef struct packed {
      side_type             side;
      logic                 sat;
      logic [DIM_BITS-1:0]  divisor;
      logic [DIM_BITS-1:0]  rem;
      logic [SIZE_BITS-1:0] low;
      logic [SIZE_BITS-1:0] quot;
   } div_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]        mx;
      logic [DIM_BITS-1:0]        my;
      logic [SIZE_BITS-1:0]       width;
      logic [SIZE_BITS-1:0]       height;
      logic signed [OFF_BITS-1:0] diff_x;
      logic signed [OFF_BITS-1:0] diff_y;
      logic                       rotated;
      logic                       sat;
   } stage_f_type;

endpackage

// ===== rtl/core/image_placement_scaler.sv =====
// Image placement scaler: pipelined destination rectangle computation.
//
// Each request word carries an image size and a monitor rectangle; one response word gives
// the destination rectangle in the selected scale mode (center, zoom fill, stretch, fit),
// with an optional width/height swap to match monitor orientation. The pipeline takes one
// word per cycle while the response side does not stall; the depth is set by the 16-bit
// quotient, produced two bits per stage over eight divider stages behind the multiply,
// compare and rounding stages. A stalled response holds its word while bubbles further up
// still fill, so requests keep flowing until the pipeline is full. Write scale_mode and
// rotate_enable only while no request is in flight.
module image_placement_scaler
   import ips_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_word_type             req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_word_type             rsp_word,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   scale_mode_type        scale_mode_ff, scale_mode_in;
   logic                  rotate_enable_ff, rotate_enable_in;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   req_word_type          a_word_ff;
   scale_mode_type        a_mode_ff;
   logic                  a_rot_en_ff;
   stage_b_type           b_ff, b_in;
   stage_c_type           c_ff, c_in;
   stage_d_type           d_ff, d_in;
   div_type               e_ff, e_in;
   div_type               div_ff [DIV_STAGES];
   div_type               div_in [DIV_STAGES];
   div_type               div_src [DIV_STAGES];
   stage_f_type           f_ff, f_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [DIM_BITS-1:0]            n_iw, n_ih, n_mw, n_mh;
   logic                           swap;
   logic [PROD_BITS+SIZE_BITS-1:0] num_ext;
   logic [PROD_BITS-1:0]           num_hi;
   logic [SIZE_BITS-1:0]           size_q;
   logic signed [OFF_BITS-1:0]     half_x, half_y;
   logic [OFF_BITS-1:0]            sum_x, sum_y;

   function automatic div_type div_step(div_type x);
      div_type           y;
      logic [DIM_BITS:0] trial;
      y = x;
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
         trial = {y.rem, y.low[SIZE_BITS-1]};
         y.low = {y.low[SIZE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, y.divisor}) begin
            trial  = trial - {1'b0, y.divisor};
            y.quot = {y.quot[SIZE_BITS-2:0], 1'b1};
         end else begin
            y.quot = {y.quot[SIZE_BITS-2:0], 1'b0};
         end
         y.rem = trial[DIM_BITS-1:0];
      end
      return y;
   endfunction

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      scale_mode_in    = scale_mode_ff;
      rotate_enable_in = rotate_enable_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE_MODE:    scale_mode_in    = scale_mode_type'(csr_wdata);
            CSR_ROTATE_ENABLE: rotate_enable_in = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff    <= MODE_FIT;
         rotate_enable_ff <= 1'b1;
      end else begin
         scale_mode_ff    <= scale_mode_in;
         rotate_enable_ff <= rotate_enable_in;
      end
   end

   // advance a stage when it is empty or its successor advances
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[ST_A];
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_word  = rsp_word_ff;

   // stage A: capture request word and settings
   always_ff @(posedge clock) begin
      if (adv[ST_A]) begin
         a_word_ff   <= req_word;
         a_mode_ff   <= scale_mode_ff;
         a_rot_en_ff <= rotate_enable_ff;
      end
   end

   // stage B: clamp zero sizes, orient, cross-multiply
   always_comb begin
      n_iw = (a_word_ff.image_width    == '0) ? DIM_BITS'(1) : a_word_ff.image_width;
      n_ih = (a_word_ff.image_height   == '0) ? DIM_BITS'(1) : a_word_ff.image_height;
      n_mw = (a_word_ff.monitor_width  == '0) ? DIM_BITS'(1) : a_word_ff.monitor_width;
      n_mh = (a_word_ff.monitor_height == '0) ? DIM_BITS'(1) : a_word_ff.monitor_height;
      swap = a_rot_en_ff && ((n_mw > n_mh && n_iw < n_ih) || (n_mw < n_mh && n_iw > n_ih));
      b_in.iw      = swap ? n_ih : n_iw;
      b_in.ih      = swap ? n_iw : n_ih;
      b_in.mw      = n_mw;
      b_in.mh      = n_mh;
      b_in.mx      = a_word_ff.monitor_x;
      b_in.my      = a_word_ff.monitor_y;
      b_in.mode    = a_mode_ff;
      b_in.rotated = swap;
      b_in.p_iw_mh = PROD_BITS'(b_in.iw) * PROD_BITS'(n_mh);
      b_in.p_mw_ih = PROD_BITS'(n_mw) * PROD_BITS'(b_in.ih);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_B]) begin
         b_ff <= b_in;
      end
   end

   // stage C: compare aspects, pick the divided side
   always_comb begin
      c_in.side.base_w  = b_ff.mw;
      c_in.side.base_h  = b_ff.mh;
      c_in.side.mw      = b_ff.mw;
      c_in.side.mh      = b_ff.mh;
      c_in.side.mx      = b_ff.mx;
      c_in.side.my      = b_ff.my;
      c_in.side.rotated = b_ff.rotated;
      c_in.side.qsel    = QSEL_NONE;
      c_in.dividend     = b_ff.p_iw_mh;
      c_in.divisor      = b_ff.ih;
      c_in.ceil_div     = 1'b0;
      unique case (b_ff.mode)
         MODE_CENTER: begin
            c_in.side.base_w = b_ff.iw;
            c_in.side.base_h = b_ff.ih;
         end
         MODE_ZOOM: begin
            c_in.ceil_div = 1'b1;
            if (b_ff.p_iw_mh > b_ff.p_mw_ih) begin
               c_in.side.qsel = QSEL_WIDTH;
            end else begin
               c_in.side.qsel = QSEL_HEIGHT;
               c_in.dividend  = b_ff.p_mw_ih;
               c_in.divisor   = b_ff.iw;
            end
         end
         MODE_STRETCH: begin
            c_in.side.qsel = QSEL_NONE;
         end
         MODE_FIT: begin
            if (b_ff.p_iw_mh >= b_ff.p_mw_ih) begin
               c_in.side.qsel = QSEL_HEIGHT;
               c_in.dividend  = b_ff.p_mw_ih;
               c_in.divisor   = b_ff.iw;
            end else begin
               c_in.side.qsel = QSEL_WIDTH;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[ST_C]) begin
         c_ff <= c_in;
      end
   end

   // stage D: bias the dividend for a ceiling quotient
   always_comb begin
      d_in.side    = c_ff.side;
      d_in.divisor = c_ff.divisor;
      d_in.numer   = c_ff.dividend
                   + (c_ff.ceil_div ? PROD_BITS'(c_ff.divisor - DIM_BITS'(1)) : '0);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_D]) begin
         d_ff <= d_in;
      end
   end

   // stage E: detect quotient overflow, seed the divider
   always_comb begin
      num_ext      = (PROD_BITS + SIZE_BITS)'(d_ff.numer);
      num_hi       = num_ext[PROD_BITS+SIZE_BITS-1:SIZE_BITS];
      e_in.side    = d_ff.side;
      e_in.divisor = d_ff.divisor;
      e_in.sat     = (d_ff.side.qsel != QSEL_NONE) && (num_hi >= PROD_BITS'(d_ff.divisor));
      e_in.rem     = num_hi[DIM_BITS-1:0];
      e_in.low     = num_ext[SIZE_BITS-1:0];
      e_in.quot    = '0;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_E]) begin
         e_ff <= e_in;
      end
   end

   // divider: restoring steps, two quotient bits per stage
   always_comb begin
      div_src[0] = e_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         div_src[k] = div_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_in[k] = div_step(div_src[k]);
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv[ST_DIV0+g]) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   // stage F: final sizes and spans left over
   always_comb begin
      size_q = div_ff[DIV_STAGES-1].sat ? {SIZE_BITS{1'b1}} : div_ff[DIV_STAGES-1].quot;
      f_in.mx      = div_ff[DIV_STAGES-1].side.mx;
      f_in.my      = div_ff[DIV_STAGES-1].side.my;
      f_in.rotated = div_ff[DIV_STAGES-1].side.rotated;
      f_in.sat     = div_ff[DIV_STAGES-1].sat;
      f_in.width   = (div_ff[DIV_STAGES-1].side.qsel == QSEL_WIDTH) ? size_q
                   : SIZE_BITS'(div_ff[DIV_STAGES-1].side.base_w);
      f_in.height  = (div_ff[DIV_STAGES-1].side.qsel == QSEL_HEIGHT) ? size_q
                   : SIZE_BITS'(div_ff[DIV_STAGES-1].side.base_h);
      f_in.diff_x  = signed'(OFF_BITS'(div_ff[DIV_STAGES-1].side.mw) - OFF_BITS'(f_in.width));
      f_in.diff_y  = signed'(OFF_BITS'(div_ff[DIV_STAGES-1].side.mh) - OFF_BITS'(f_in.height));
   end

   always_ff @(posedge clock) begin
      if (adv[ST_F]) begin
         f_ff <= f_in;
      end
   end

   // output stage: center with halving toward zero
   always_comb begin
      half_x = f_ff.diff_x >>> 1;
      half_y = f_ff.diff_y >>> 1;
      sum_x  = OFF_BITS'(f_ff.mx) + unsigned'(half_x)
             + OFF_BITS'(f_ff.diff_x[OFF_BITS-1] & f_ff.diff_x[0]);
      sum_y  = OFF_BITS'(f_ff.my) + unsigned'(half_y)
             + OFF_BITS'(f_ff.diff_y[OFF_BITS-1] & f_ff.diff_y[0]);
      rsp_word_in.dest_x      = signed'(sum_x[SIZE_BITS-1:0]);
      rsp_word_in.dest_y      = signed'(sum_y[SIZE_BITS-1:0]);
      rsp_word_in.dest_width  = f_ff.width;
      rsp_word_in.dest_height = f_ff.height;
      rsp_word_in.rotated     = f_ff.rotated;
      rsp_word_in.saturated   = f_ff.sat;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Testbench of the image placement scaler: directed corners, random traffic and backpressure.
module testbench;
   import ips_pkg::*;

   localparam int  CLOCK_HALF   = 2;
   localparam int  RESET_CYCLES = 10;
   localparam int  DRAIN_CYCLES = 40;
   localparam int  HOLD_CYCLES  = 300;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  MAX_REPORTS  = 10;
   localparam int  DIM_MAX      = (1 << DIM_BITS) - 1;
   localparam int  RANDOM_PHASES = 12;
   localparam int  PHASE_WORDS   = 75;
   localparam int  PRESSURE_WORDS = 100;
   localparam longint SIZE_MAX  = 65535;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_word_type             req_word;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_word_type             rsp_word;
   logic                     csr_valid;
   logic                     csr_ready;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   scale_mode_type cfg_mode;
   logic           cfg_rotate;
   rsp_word_type   pending_placements[$];

   int req_idle_pct;
   int rsp_idle_pct;
   int hold_requests;
   int hold_seen;
   int hold_left;
   int cycle_count;
   int mismatch_count;
   int placed_count;
   int checked_count;
   int rotated_count;
   int saturated_count;
   int setting_count;

   image_placement_scaler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d placements outstanding",
                  cycle_count, pending_placements.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [SIZE_BITS-1:0] centered(longint origin, longint span,
                                                     longint size);
      longint offset;
      offset = origin + (span - size) / 2;
      return offset[SIZE_BITS-1:0];
   endfunction

   function automatic rsp_word_type place_image(req_word_type w);
      rsp_word_type p;
      longint iw, ih, mx, my, mw, mh, swap, raw_w, raw_h, nw, nh;
      logic   wide, center_x, center_y;
      iw = (w.image_width == 0) ? 1 : longint'(w.image_width);
      ih = (w.image_height == 0) ? 1 : longint'(w.image_height);
      mw = (w.monitor_width == 0) ? 1 : longint'(w.monitor_width);
      mh = (w.monitor_height == 0) ? 1 : longint'(w.monitor_height);
      mx = longint'(w.monitor_x);
      my = longint'(w.monitor_y);
      p.rotated = cfg_rotate && ((mw > mh && iw < ih) || (mw < mh && iw > ih));
      if (p.rotated) begin
         swap = iw;
         iw   = ih;
         ih   = swap;
      end
      wide = 1'b0;
      case (cfg_mode)
         MODE_CENTER: begin
            raw_w = iw;
            raw_h = ih;
         end
         MODE_ZOOM: begin
            wide = (iw * mh > mw * ih);
            if (wide) begin
               raw_h = mh;
               raw_w = (iw * mh + ih - 1) / ih;
            end else begin
               raw_w = mw;
               raw_h = (ih * mw + iw - 1) / iw;
            end
         end
         MODE_STRETCH: begin
            raw_w = mw;
            raw_h = mh;
         end
         default: begin
            if (iw * mh >= ih * mw) begin
               raw_w = mw;
               raw_h = (ih * mw) / iw;
            end else begin
               raw_w = (iw * mh) / ih;
               raw_h = mh;
            end
         end
      endcase
      p.saturated = (raw_w > SIZE_MAX) || (raw_h > SIZE_MAX);
      nw = (raw_w > SIZE_MAX) ? SIZE_MAX : raw_w;
      nh = (raw_h > SIZE_MAX) ? SIZE_MAX : raw_h;
      center_x = (cfg_mode == MODE_CENTER) || (cfg_mode == MODE_FIT) ||
                 (cfg_mode == MODE_ZOOM && wide);
      center_y = (cfg_mode == MODE_CENTER) || (cfg_mode == MODE_FIT) ||
                 (cfg_mode == MODE_ZOOM && !wide);
      p.dest_x      = center_x ? centered(mx, mw, nw) : mx[SIZE_BITS-1:0];
      p.dest_y      = center_y ? centered(my, mh, nh) : my[SIZE_BITS-1:0];
      p.dest_width  = nw[SIZE_BITS-1:0];
      p.dest_height = nh[SIZE_BITS-1:0];
      return p;
   endfunction

   function automatic req_word_type make_request(int iw, int ih, int mx, int my,
                                                 int mw, int mh);
      req_word_type w;
      w.image_width    = iw[DIM_BITS-1:0];
      w.image_height   = ih[DIM_BITS-1:0];
      w.monitor_x      = mx[DIM_BITS-1:0];
      w.monitor_y      = my[DIM_BITS-1:0];
      w.monitor_width  = mw[DIM_BITS-1:0];
      w.monitor_height = mh[DIM_BITS-1:0];
      return w;
   endfunction

   function automatic int random_dim();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return DIM_MAX;
         2, 3:    return $urandom_range(1, 16);
         4:       return $urandom_range(1, 256);
         default: return $urandom_range(0, DIM_MAX);
      endcase
   endfunction

   function automatic req_word_type random_request();
      req_word_type w;
      w = make_request(random_dim(), random_dim(), random_dim(), random_dim(),
                       random_dim(), random_dim());
      case ($urandom_range(0, 7))
         0: begin
            w.image_width  = w.monitor_width;
            w.image_height = w.monitor_height;
         end
         1: begin
            w.image_width  = w.monitor_height;
            w.image_height = w.monitor_width;
         end
         2: begin
            w.image_width  = w.monitor_width >> 1;
            w.image_height = w.monitor_height >> 1;
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_request(input req_word_type w);
      rsp_word_type p;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = place_image(w);
      pending_placements.push_back(p);
      placed_count++;
      rotated_count   += int'(p.rotated);
      saturated_count += int'(p.saturated);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      wait_drained();
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SCALE_MODE) cfg_mode = scale_mode_type'(data);
      else cfg_rotate = data[0];
      setting_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [SIZE_BITS-1:0] want,
                                  input logic [SIZE_BITS-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on placement %0d, %s: expected 0x%04h, got 0x%04h",
                  checked_count, what, want, got);
   endtask

   task automatic compare_field(input string what, input logic [SIZE_BITS-1:0] want,
                                input logic [SIZE_BITS-1:0] got);
      if (got !== want) report_mismatch(what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_placements.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_word.dest_width);
         end else begin
            want = pending_placements.pop_front();
            compare_field("dest_x", want.dest_x, rsp_word.dest_x);
            compare_field("dest_y", want.dest_y, rsp_word.dest_y);
            compare_field("dest_width", want.dest_width, rsp_word.dest_width);
            compare_field("dest_height", want.dest_height, rsp_word.dest_height);
            compare_field("rotated", SIZE_BITS'(want.rotated), SIZE_BITS'(rsp_word.rotated));
            compare_field("saturated", SIZE_BITS'(want.saturated),
                          SIZE_BITS'(rsp_word.saturated));
         end
         checked_count++;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic test_directed_corners();
      req_word_type   corners[5];
      scale_mode_type modes[4];
      modes[0]   = MODE_FIT;
      modes[1]   = MODE_CENTER;
      modes[2]   = MODE_ZOOM;
      modes[3]   = MODE_STRETCH;
      corners[0] = make_request(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
      corners[1] = make_request(0, 0, 0, 0, 0, 0);
      corners[2] = make_request(1, DIM_MAX, 0, 0, DIM_MAX, 1);
      corners[3] = make_request(DIM_MAX, 2, DIM_MAX, 0, 3, DIM_MAX - 1);
      corners[4] = make_request(DIM_MAX, 1, 1234, 4321, DIM_MAX, DIM_MAX - 1);
      foreach (modes[m]) begin
         if (m != 0) write_register(CSR_SCALE_MODE, modes[m]);
         foreach (corners[k]) send_request(corners[k]);
      end
      write_register(CSR_ROTATE_ENABLE, 2'b10);
      write_register(CSR_SCALE_MODE, MODE_ZOOM);
      send_request(make_request(DIM_MAX, 1, 0, 0, 1, DIM_MAX));
      send_request(make_request(1, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 1));
      send_request(make_request(DIM_MAX, 1, 0, DIM_MAX, DIM_MAX, 1));
   endtask

   task automatic test_random_phases();
      logic rotate_bit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         rotate_bit = (phase % 3 != 0);
         write_register(CSR_SCALE_MODE, scale_mode_type'(phase % 4));
         write_register(CSR_ROTATE_ENABLE, {1'($urandom_range(0, 1)), rotate_bit});
         req_idle_pct = (phase == 5) ? 0 : 32;
         rsp_idle_pct = (phase == 5) ? 0 : 32;
         for (int n = 0; n < PHASE_WORDS; n++) send_request(random_request());
      end
   endtask

   task automatic test_backpressure();
      write_register(CSR_SCALE_MODE, MODE_ZOOM);
      write_register(CSR_ROTATE_ENABLE, 2'b01);
      req_idle_pct = 0;
      rsp_idle_pct = 32;
      hold_requests++;
      for (int n = 0; n < PRESSURE_WORDS; n++) send_request(random_request());
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SCALE_MODE;
      csr_wdata = '0;
      cfg_mode  = MODE_FIT;
      cfg_rotate = 1'b1;
      req_idle_pct = 32;
      rsp_idle_pct = 32;
      hold_requests = 0;
      cycle_count = 0;
      mismatch_count = 0;
      placed_count = 0;
      checked_count = 0;
      rotated_count = 0;
      saturated_count = 0;
      setting_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_phases();
      test_backpressure();
      wait_drained();

      $display("%0d placements checked across %0d register writes", checked_count,
               setting_count);
      $display("%0d rotated, %0d clamped, %0d mismatches", rotated_count,
               saturated_count, mismatch_count);
      if (mismatch_count == 0 && pending_placements.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
